### rtl/core/bvdr_pkg.sv
// Package for the battery voltage drop reporter: widths, reset values,
// register indexes and the request/response structs of the serial units.
// Depends on nothing; every other file of the block uses it.
package bvdr_pkg;

    // Converter code width and the byte-padded input data width.
    localparam int ADC_BITS    = 10;
    localparam int S_TDATA_W   = ((ADC_BITS + 7) / 8) * 8;

    // Datapath widths.
    localparam int SUM_W       = 16;
    localparam int CNT_W       = 7;
    localparam int MVLSB_W     = 4;
    localparam int MV_W        = 14;
    localparam int PROD_W      = SUM_W + MVLSB_W;
    localparam int DVS_W       = 7;
    localparam int Q100_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int CFG_W       = 14;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 2;

    // Constants of the arithmetic.
    localparam logic [MV_W-1:0]    LEVEL_MAX      = 14'd16383;
    localparam logic [DVS_W-1:0]   DIGIT_DIVISOR  = 7'd100;
    localparam logic [DIGIT_W-1:0] WHOLE_MAX      = 4'd15;
    localparam logic [DIGIT_W-1:0] TENTHS_MAX     = 4'd9;
    // q / 10 for q < 256 is (q * 205) >> 11.
    localparam logic [Q100_W-1:0]  DIV10_RECIP    = 8'd205;
    localparam int                 DIV10_SHIFT    = 11;

    // Register reset values.
    localparam logic [CNT_W-1:0]   SAMPLES_RESET  = 7'd10;
    localparam logic [MVLSB_W-1:0] MV_LSB_RESET   = 4'd5;
    localparam logic [MV_W-1:0]    LOW_THR_RESET  = 14'd3000;
    localparam logic [MV_W-1:0]    DROP_THR_RESET = 14'd100;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SAMPLES    = 2'd0,
        CFG_MV_PER_LSB = 2'd1,
        CFG_LOW_THR    = 2'd2,
        CFG_DROP_THR   = 2'd3
    } cfg_index_t;

    // Serial divider request and response.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    // Serial multiplier request and response.
    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   multiplicand;
        logic [MVLSB_W-1:0] multiplier;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } mul_rsp_t;

endpackage

### rtl/core/bvdr_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on bvdr_pkg for widths and the request/response structs.
module bvdr_serial_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  bvdr_pkg::div_req_t req,
    output bvdr_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [3:0]                    cnt_reg, cnt_next;
    logic [bvdr_pkg::SUM_W-1:0]    dvd_reg, dvd_next;
    logic [bvdr_pkg::DVS_W-1:0]    rem_reg, rem_next;
    logic [bvdr_pkg::DVS_W-1:0]    dvs_reg, dvs_next;
    logic [bvdr_pkg::DVS_W:0]      trial;
    logic [bvdr_pkg::DVS_W:0]      diff;
    logic                          ge;

    // One restoring step: bring down the next dividend bit and try the subtract.
    assign trial = {rem_reg, dvd_reg[bvdr_pkg::SUM_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[bvdr_pkg::DVS_W-1:0] : trial[bvdr_pkg::DVS_W-1:0];
            dvd_next = {dvd_reg[bvdr_pkg::SUM_W-2:0], ge};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // After the last step the shifted dividend holds the quotient.
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

### rtl/core/bvdr_serial_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, MSB first.
// Depends on bvdr_pkg for widths and the request/response structs.
module bvdr_serial_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  bvdr_pkg::mul_req_t req,
    output bvdr_pkg::mul_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [1:0]                     cnt_reg, cnt_next;
    logic [bvdr_pkg::PROD_W-1:0]    acc_reg, acc_next;
    logic [bvdr_pkg::SUM_W-1:0]     mcand_reg, mcand_next;
    logic [bvdr_pkg::MVLSB_W-1:0]   mplier_reg, mplier_next;
    logic [bvdr_pkg::PROD_W-1:0]    addend;

    // Partial product for the current multiplier bit.
    assign addend = mplier_reg[bvdr_pkg::MVLSB_W-1]
                  ? {{bvdr_pkg::MVLSB_W{1'b0}}, mcand_reg} : '0;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (req.start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = req.multiplicand;
            mplier_next = req.multiplier;
        end else if (busy_reg) begin
            acc_next    = {acc_reg[bvdr_pkg::PROD_W-2:0], 1'b0} + addend;
            mplier_next = {mplier_reg[bvdr_pkg::MVLSB_W-2:0], 1'b0};
            cnt_next    = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

### rtl/core/battery_voltage_drop_reporter_unit.sv
// Top level of the battery voltage drop reporter: stream ports, registers,
// the measurement sequencer and the output register.
// Depends on bvdr_pkg, bvdr_serial_div and bvdr_serial_mul.

// A code that does not complete a measurement only adds to the running sum and
// count and gives no result. The code that completes one starts a sequence: a
// serial divide of the sum by the sample count, a serial scale by mv_per_lsb on
// the bit-serial multiplier, and a second divide of the level by 100 for the
// digits; both divides share the one bit-serial divider. No new code is taken
// during that sequence. The finished result sits in an output register, so the
// next code is taken while it waits on m_tready.
module battery_voltage_drop_reporter_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [bvdr_pkg::CFG_W-1:0]     cfg_wdata,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata fields from bit 0: adc_code, zero padding.
    input  logic [bvdr_pkg::S_TDATA_W-1:0] s_tdata,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata fields from bit 0: level_mv, whole_volts, tenths_digit, padding.
    output logic [bvdr_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser fields from bit 0: low_battery, report_now.
    output logic [bvdr_pkg::M_TUSER_W-1:0] m_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_AVG,
        S_MUL,
        S_LEVEL,
        S_DIV_DIG,
        S_OUT
    } state_t;

    state_t                            state_reg, state_next;

    // Configuration registers.
    logic [bvdr_pkg::CNT_W-1:0]        samples_reg;
    logic [bvdr_pkg::MVLSB_W-1:0]      mv_lsb_reg;
    logic [bvdr_pkg::MV_W-1:0]         low_thr_reg;
    logic [bvdr_pkg::MV_W-1:0]         drop_thr_reg;

    // Measurement state.
    logic [bvdr_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [bvdr_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [bvdr_pkg::MV_W-1:0]         last_mv_reg, last_mv_next;
    logic                              first_done_reg, first_done_next;
    logic [bvdr_pkg::MV_W-1:0]         level_reg, level_next;
    logic [bvdr_pkg::Q100_W-1:0]       q100_reg, q100_next;

    // Output register.
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [bvdr_pkg::M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [bvdr_pkg::M_TUSER_W-1:0]    m_tuser_reg, m_tuser_next;

    logic                              accept;
    logic [bvdr_pkg::SUM_W-1:0]        sum_add;
    logic [bvdr_pkg::CNT_W-1:0]        cnt_inc;
    logic [bvdr_pkg::CNT_W-1:0]        n_eff;
    logic                              complete;
    logic                              out_free;
    logic                              low_flag;
    logic                              report;
    logic [15:0]                       recip_prod;
    logic [bvdr_pkg::DIGIT_W:0]        whole_raw;
    logic [bvdr_pkg::Q100_W-1:0]       whole_x10;
    logic [bvdr_pkg::Q100_W-1:0]       tenths_raw;
    logic [bvdr_pkg::DIGIT_W-1:0]      whole_sat;
    logic [bvdr_pkg::DIGIT_W-1:0]      whole_out;
    logic [bvdr_pkg::DIGIT_W-1:0]      tenths_out;

    bvdr_pkg::div_req_t                div_req;
    bvdr_pkg::div_rsp_t                div_rsp;
    bvdr_pkg::mul_req_t                mul_req;
    bvdr_pkg::mul_rsp_t                mul_rsp;

    bvdr_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    bvdr_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Running sum and count for the request being taken.
    assign sum_add  = sum_reg + {{(bvdr_pkg::SUM_W - bvdr_pkg::ADC_BITS){1'b0}},
                                 s_tdata[bvdr_pkg::ADC_BITS-1:0]};
    assign cnt_inc  = count_reg + {{(bvdr_pkg::CNT_W - 1){1'b0}}, 1'b1};
    assign n_eff    = (samples_reg == '0) ? {{(bvdr_pkg::CNT_W - 1){1'b0}}, 1'b1}
                                          : samples_reg;
    assign complete = (cnt_inc >= n_eff) || (cnt_inc == '0);

    // Flags of the finished measurement.
    assign low_flag = first_done_reg && (level_reg < low_thr_reg);
    assign report   = !first_done_reg
                   || ((last_mv_reg > level_reg)
                       && ((last_mv_reg - level_reg) > drop_thr_reg));

    // Digits from level / 100: whole volts by reciprocal, tenths as the remainder.
    assign recip_prod = {8'd0, q100_reg} * {8'd0, bvdr_pkg::DIV10_RECIP};
    assign whole_raw  = recip_prod[bvdr_pkg::DIV10_SHIFT +: (bvdr_pkg::DIGIT_W + 1)];
    assign whole_x10  = {{(bvdr_pkg::Q100_W - bvdr_pkg::DIGIT_W - 1){1'b0}}, whole_raw}
                        * 8'd10;
    assign tenths_raw = q100_reg - whole_x10;
    assign whole_sat  = whole_raw[bvdr_pkg::DIGIT_W] ? bvdr_pkg::WHOLE_MAX
                                                     : whole_raw[bvdr_pkg::DIGIT_W-1:0];
    assign whole_out  = report ? whole_sat : '0;
    assign tenths_out = report ? tenths_raw[bvdr_pkg::DIGIT_W-1:0] : '0;

    // Sequencer and datapath next values.
    always_comb begin
        state_next       = state_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        last_mv_next     = last_mv_reg;
        first_done_next  = first_done_reg;
        level_next       = level_reg;
        q100_next        = q100_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        div_req          = '0;
        mul_req          = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (complete) begin
                        sum_next         = '0;
                        count_next       = '0;
                        div_req.start    = 1'b1;
                        div_req.dividend = sum_add;
                        div_req.divisor  = n_eff;
                        state_next       = S_DIV_AVG;
                    end else begin
                        sum_next   = sum_add;
                        count_next = cnt_inc;
                    end
                end
            end
            S_DIV_AVG: begin
                if (div_rsp.done) begin
                    mul_req.start        = 1'b1;
                    mul_req.multiplicand = div_rsp.quotient;
                    mul_req.multiplier   = mv_lsb_reg;
                    state_next           = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_rsp.done) begin
                    if (mul_rsp.product > {{(bvdr_pkg::PROD_W - bvdr_pkg::MV_W){1'b0}},
                                           bvdr_pkg::LEVEL_MAX}) begin
                        level_next = bvdr_pkg::LEVEL_MAX;
                    end else begin
                        level_next = mul_rsp.product[bvdr_pkg::MV_W-1:0];
                    end
                    state_next = S_LEVEL;
                end
            end
            S_LEVEL: begin
                div_req.start    = 1'b1;
                div_req.dividend = {{(bvdr_pkg::SUM_W - bvdr_pkg::MV_W){1'b0}}, level_reg};
                div_req.divisor  = bvdr_pkg::DIGIT_DIVISOR;
                state_next       = S_DIV_DIG;
            end
            S_DIV_DIG: begin
                if (div_rsp.done) begin
                    q100_next  = div_rsp.quotient[bvdr_pkg::Q100_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = {2'b00, tenths_out, whole_out, level_reg};
                    m_tuser_next    = {report, low_flag};
                    first_done_next = 1'b1;
                    if (report) begin
                        last_mv_next = level_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            samples_reg    <= bvdr_pkg::SAMPLES_RESET;
            mv_lsb_reg     <= bvdr_pkg::MV_LSB_RESET;
            low_thr_reg    <= bvdr_pkg::LOW_THR_RESET;
            drop_thr_reg   <= bvdr_pkg::DROP_THR_RESET;
            sum_reg        <= '0;
            count_reg      <= '0;
            last_mv_reg    <= '0;
            first_done_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            last_mv_reg    <= last_mv_next;
            first_done_reg <= first_done_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we) begin
                case (bvdr_pkg::cfg_index_t'(cfg_index))
                    bvdr_pkg::CFG_SAMPLES:    samples_reg  <= cfg_wdata[bvdr_pkg::CNT_W-1:0];
                    bvdr_pkg::CFG_MV_PER_LSB: mv_lsb_reg   <= cfg_wdata[bvdr_pkg::MVLSB_W-1:0];
                    bvdr_pkg::CFG_LOW_THR:    low_thr_reg  <= cfg_wdata;
                    bvdr_pkg::CFG_DROP_THR:   drop_thr_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        level_reg   <= level_next;
        q100_reg    <= q100_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The first result after reset always reports and is never flagged low.
    a_first_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free && !first_done_reg) |=> (m_tuser[1] && !m_tuser[0]))
        else $error("first measurement did not report or was flagged low");

    // Digits are zero whenever no report is made.
    a_no_report_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[21:14] == '0))
        else $error("digits set on a result without a report");

    // The tenths digit is a decimal digit.
    a_tenths_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21:18] <= bvdr_pkg::TENTHS_MAX))
        else $error("tenths digit out of range");

    // The averaging divide hands straight over to the scaling multiply.
    a_div_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV_AVG && div_rsp.done) |=> (state_reg == S_MUL))
        else $error("average divide did not start the scale");

    // A stored report level is one that was actually reported.
    a_last_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free && report) |=> (last_mv_reg == m_tdata[13:0]))
        else $error("last reported level not updated");

endmodule

### verif/tb_battery_voltage_drop_reporter_unit.sv
// Self-checking testbench for battery_voltage_drop_reporter_unit: directed corner
// tests, then random configuration phases, all checked against a built-in predictor.
// Depends on bvdr_pkg and the RTL of the block only.
module tb_battery_voltage_drop_reporter_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES  = 60;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam int unsigned RANDOM_PHASES  = 10;
    localparam int unsigned PHASE_ITEMS    = 80;
    localparam int unsigned CODE_MAX       = (1 << bvdr_pkg::ADC_BITS) - 1;

    // One measurement as it leaves the block.
    typedef struct {
        logic [bvdr_pkg::MV_W-1:0]    level_mv;
        logic                         low_battery;
        logic                         report_now;
        logic [bvdr_pkg::DIGIT_W-1:0] whole_volts;
        logic [bvdr_pkg::DIGIT_W-1:0] tenths_digit;
    } reading_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_we;
    logic [1:0]                     cfg_index;
    logic [bvdr_pkg::CFG_W-1:0]     cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [bvdr_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [bvdr_pkg::M_TDATA_W-1:0] m_tdata;
    logic [bvdr_pkg::M_TUSER_W-1:0] m_tuser;

    // Predictor state and its copy of the registers.
    logic [bvdr_pkg::SUM_W-1:0]   acc_sum;
    logic [bvdr_pkg::CNT_W-1:0]   acc_count;
    logic [bvdr_pkg::MV_W-1:0]    last_shown_mv;
    bit                           first_shown;
    logic [bvdr_pkg::CNT_W-1:0]   samples_reg;
    logic [bvdr_pkg::MVLSB_W-1:0] mv_lsb_reg;
    logic [bvdr_pkg::MV_W-1:0]    low_thr_reg;
    logic [bvdr_pkg::MV_W-1:0]    drop_thr_reg;

    reading_t    expected_readings[$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          rx_hold_req = 1'b0;

    battery_voltage_drop_reporter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap(bit enabled);
        int unsigned r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Accumulate one converter code; a completed measurement queues its reading.
    function automatic void accumulate_code(logic [bvdr_pkg::ADC_BITS-1:0] code);
        int unsigned n;
        int unsigned lvl;
        int unsigned whole;
        int unsigned tenths;
        reading_t    r;
        acc_sum   = acc_sum + code;
        acc_count = acc_count + 1'b1;
        n = (samples_reg == 0) ? 1 : samples_reg;
        if (acc_count != 0 && acc_count < n) return;
        lvl = (acc_sum / n) * mv_lsb_reg;
        if (lvl > 16383) lvl = 16383;
        acc_sum   = '0;
        acc_count = '0;
        r.level_mv     = lvl[bvdr_pkg::MV_W-1:0];
        r.whole_volts  = '0;
        r.tenths_digit = '0;
        if (!first_shown) begin
            r.low_battery = 1'b0;
            r.report_now  = 1'b1;
            first_shown   = 1'b1;
        end else begin
            r.low_battery = lvl < low_thr_reg;
            r.report_now  = (last_shown_mv > lvl) && ((last_shown_mv - lvl) > drop_thr_reg);
        end
        if (r.report_now) begin
            whole  = lvl / 1000;
            if (whole > 15) whole = 15;
            tenths = (lvl / 100) % 10;
            r.whole_volts  = whole[bvdr_pkg::DIGIT_W-1:0];
            r.tenths_digit = tenths[bvdr_pkg::DIGIT_W-1:0];
            last_shown_mv  = lvl[bvdr_pkg::MV_W-1:0];
        end
        expected_readings.push_back(r);
    endfunction

    // Offer one code and wait until the block takes it.
    task automatic send_code(int unsigned value);
        int unsigned                   gap;
        logic [bvdr_pkg::ADC_BITS-1:0] code;
        code = value[bvdr_pkg::ADC_BITS-1:0];
        gap  = pick_gap(tx_idle_on);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(bvdr_pkg::S_TDATA_W - bvdr_pkg::ADC_BITS){1'b0}}, code};
        do @(posedge aclk); while (!s_tready);
        accumulate_code(code);
        @(negedge aclk);
    endtask

    // Stop offering, wait for every pending reading, then let the block settle.
    task automatic wait_until_drained();
        s_tvalid = 1'b0;
        while (expected_readings.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic cfg_write(bvdr_pkg::cfg_index_t idx, int unsigned value);
        logic [bvdr_pkg::CFG_W-1:0] data;
        data      = value[bvdr_pkg::CFG_W-1:0];
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            bvdr_pkg::CFG_SAMPLES:    samples_reg  = data[bvdr_pkg::CNT_W-1:0];
            bvdr_pkg::CFG_MV_PER_LSB: mv_lsb_reg   = data[bvdr_pkg::MVLSB_W-1:0];
            bvdr_pkg::CFG_LOW_THR:    low_thr_reg  = data[bvdr_pkg::MV_W-1:0];
            bvdr_pkg::CFG_DROP_THR:   drop_thr_reg = data[bvdr_pkg::MV_W-1:0];
            default: ;
        endcase
    endtask

    function automatic int unsigned pick_samples();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (r)
            0: return 0;
            1: return 64;
            2: return 127;
            3: return $urandom_range(0, (1 << bvdr_pkg::CFG_W) - 1);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int unsigned pick_threshold(int unsigned typical_max);
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 0;
            1: return 15345;
            2: return (1 << bvdr_pkg::CFG_W) - 1;
            3: return $urandom_range(0, (1 << bvdr_pkg::CFG_W) - 1);
            default: return $urandom_range(0, typical_max);
        endcase
    endfunction

    // First measurement under reset settings: always reported, never low.
    task automatic test_first_measurement();
        for (int i = 0; i < 10; i++) begin
            send_code((i % 2 == 0) ? CODE_MAX : 0);
        end
        wait_until_drained();
    endtask

    // Zero sample count, zero scale, threshold extremes, level saturation.
    task automatic test_corner_cases();
        cfg_write(bvdr_pkg::CFG_SAMPLES, 0);
        cfg_write(bvdr_pkg::CFG_MV_PER_LSB, 15);
        send_code(CODE_MAX);
        send_code(0);
        send_code(1);
        wait_until_drained();
        cfg_write(bvdr_pkg::CFG_MV_PER_LSB, 0);
        send_code(CODE_MAX);
        wait_until_drained();
        cfg_write(bvdr_pkg::CFG_MV_PER_LSB, 15);
        cfg_write(bvdr_pkg::CFG_LOW_THR, 15345);
        cfg_write(bvdr_pkg::CFG_DROP_THR, 0);
        send_code(CODE_MAX - 1);
        send_code(CODE_MAX - 2);
        wait_until_drained();
        cfg_write(bvdr_pkg::CFG_LOW_THR, 0);
        cfg_write(bvdr_pkg::CFG_DROP_THR, 15345);
        send_code(0);
        wait_until_drained();
        // Lower the count mid-measurement so four codes summed over a count of one saturate.
        cfg_write(bvdr_pkg::CFG_SAMPLES, 64);
        send_code(CODE_MAX);
        send_code(CODE_MAX);
        send_code(CODE_MAX);
        wait_until_drained();
        cfg_write(bvdr_pkg::CFG_SAMPLES, 1);
        send_code(CODE_MAX);
        send_code(0);
        wait_until_drained();
    endtask

    // A long measurement whose sum wraps at 16 bits.
    task automatic test_sum_wrap();
        cfg_write(bvdr_pkg::CFG_SAMPLES, 127);
        cfg_write(bvdr_pkg::CFG_MV_PER_LSB, 1);
        for (int i = 0; i < 127; i++) begin
            send_code($urandom_range(600, CODE_MAX));
        end
        wait_until_drained();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        cfg_write(bvdr_pkg::CFG_SAMPLES, 1);
        cfg_write(bvdr_pkg::CFG_MV_PER_LSB, 5);
        cfg_write(bvdr_pkg::CFG_DROP_THR, 20);
        tx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_code(CODE_MAX - 10 * i);
        end
        tx_idle_on = 1'b1;
        wait_until_drained();
    endtask

    // Random settings per phase; half of the phases send slowly falling levels with noise.
    task automatic test_random_phases();
        int unsigned mode;
        int          base;
        int          v;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_until_drained();
            cfg_write(bvdr_pkg::CFG_SAMPLES, pick_samples());
            cfg_write(bvdr_pkg::CFG_MV_PER_LSB, $urandom_range(0, 15));
            cfg_write(bvdr_pkg::CFG_LOW_THR, pick_threshold((1 << bvdr_pkg::CFG_W) - 1));
            cfg_write(bvdr_pkg::CFG_DROP_THR, pick_threshold(300));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            mode = $urandom_range(0, 3);
            base = $urandom_range(0, CODE_MAX);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case (mode)
                    0, 1: begin
                        if ($urandom_range(0, 31) == 0) base = $urandom_range(600, CODE_MAX);
                        else if (base >= 4) base = base - int'($urandom_range(0, 4));
                        v = base + int'($urandom_range(0, 6)) - 3;
                    end
                    2: begin
                        v = $urandom_range(0, CODE_MAX);
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0: v = 0;
                            1: v = CODE_MAX;
                            2: v = 1;
                            default: v = $urandom_range(0, CODE_MAX);
                        endcase
                    end
                endcase
                if (v < 0) v = 0;
                if (v > int'(CODE_MAX)) v = CODE_MAX;
                send_code(v);
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : rx_side
        int unsigned stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall = RX_HOLD_CYCLES;
            end
            if (stall != 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                stall = pick_gap(rx_idle_on);
            end
        end
    end

    // Compare each accepted result with the oldest expected reading.
    always @(posedge aclk) begin
        reading_t want;
        reading_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.level_mv     = m_tdata[bvdr_pkg::MV_W-1:0];
            got.whole_volts  = m_tdata[bvdr_pkg::MV_W +: bvdr_pkg::DIGIT_W];
            got.tenths_digit = m_tdata[bvdr_pkg::MV_W + bvdr_pkg::DIGIT_W +: bvdr_pkg::DIGIT_W];
            got.low_battery  = m_tuser[0];
            got.report_now   = m_tuser[1];
            if (expected_readings.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected result level=%0d", $realtime, got.level_mv);
                mismatch_count++;
            end else begin
                want = expected_readings.pop_front();
                if (got.level_mv !== want.level_mv || got.low_battery !== want.low_battery ||
                    got.report_now !== want.report_now ||
                    got.whole_volts !== want.whole_volts ||
                    got.tenths_digit !== want.tenths_digit) begin
                    if (mismatch_count < 10)
                        $display("%0t: mismatch exp lvl=%0d low=%0b rep=%0b v=%0d.%0d,",
                                 $realtime, want.level_mv, want.low_battery, want.report_now,
                                 want.whole_volts, want.tenths_digit,
                                 " got lvl=%0d low=%0b rep=%0b v=%0d.%0d",
                                 got.level_mv, got.low_battery, got.report_now,
                                 got.whole_volts, got.tenths_digit);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without any request moving ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = bvdr_pkg::CFG_SAMPLES;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        acc_sum       = '0;
        acc_count     = '0;
        last_shown_mv = '0;
        first_shown   = 1'b0;
        samples_reg   = bvdr_pkg::SAMPLES_RESET;
        mv_lsb_reg    = bvdr_pkg::MV_LSB_RESET;
        low_thr_reg   = bvdr_pkg::LOW_THR_RESET;
        drop_thr_reg  = bvdr_pkg::DROP_THR_RESET;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_first_measurement();
        test_corner_cases();
        test_sum_wrap();
        test_backpressure();
        test_random_phases();
        wait_until_drained();

        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
